// ----- rtl/mf3_pkg.sv -----
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 median filter
// Register map, reset values, queue sizing and the result position type.
// ----------------------------------------------------------------------------
package mf3_pkg;

   // default sizes handed to the top level parameters
   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int PIXEL_BITS_DEFAULT = 8;

   // rank of the median among nine sorted values
   localparam int MEDIAN_RANK = 4;

   // smallest frame side that the counters accept
   localparam int MIN_SIDE = 3;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

   // register indexes (byte address 4*index)
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // register reset values
   localparam logic [10:0] IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;

   // frame geometry as seen by the front
   typedef struct packed {
      logic [10:0] image_width;
      logic [15:0] image_height;
   } cfg_type;

   // position tag of one result
   typedef struct packed {
      logic [9:0]  column;
      logic [15:0] row;
   } pos_type;

endpackage

// ----- rtl/median_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// median_filter_3x3: streaming 3x3 median filter over a raster pixel stream
// Throughput: one pixel per cycle while the queue has room, set by one read
// and one write of each line store per cycle and the fully pipelined median
// network. A result follows the pixel one row below and one column right of
// its center via intake, queue, network and result registers (plus stalls).
// Reset: clears counters, window, queue and pipeline; width 640, height 480.
// Line stores are not cleared: no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
module median_filter_3x3 #(
   parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // pixel input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] pixel_in
   // median output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [7:0] median_value, [17:8] out_column,
                                     // [33:18] out_row, [39:34] zero
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [10:0]                       image_width_ff;
   logic [15:0]                       image_height_ff;
   logic                              csr_write;
   logic                              reg_index;
   mf3_pkg::cfg_type                  cfg;
   logic                              push;
   logic [8:0][PIXEL_BITS-1:0]        push_pixels;
   mf3_pkg::pos_type                  push_pos;
   logic                              pop;
   logic                              head_valid;
   logic [8:0][PIXEL_BITS-1:0]        head_pixels;
   mf3_pkg::pos_type                  head_pos;
   logic [mf3_pkg::LEVEL_BITS-1:0]    queue_level;
   logic [7:0]                        median_value;
   mf3_pkg::pos_type                  median_pos;

   // register port: write on the access cycle
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= mf3_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= mf3_pkg::IMAGE_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            mf3_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr_pwdata[10:0];
            mf3_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read back the addressed register
   always_comb begin
      unique case (reg_index)
         mf3_pkg::REG_IMAGE_WIDTH:  csr_prdata = {21'b0, image_width_ff};
         mf3_pkg::REG_IMAGE_HEIGHT: csr_prdata = {16'b0, image_height_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   assign cfg.image_width  = image_width_ff;
   assign cfg.image_height = image_height_ff;

   mf3_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .queue_level (queue_level),
      .push        (push),
      .push_pixels (push_pixels),
      .push_pos    (push_pos)
   );

   mf3_queue #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_pixels (push_pixels),
      .push_pos    (push_pos),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_pixels (head_pixels),
      .head_pos    (head_pos),
      .level       (queue_level)
   );

   mf3_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_pixels  (head_pixels),
      .head_pos     (head_pos),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .median_value (median_value),
      .median_pos   (median_pos)
   );

   // pack the result transaction
   assign rsp_tdata = {6'b0, median_pos.row, median_pos.column, median_value};

endmodule

// ----- rtl/mf3_front.sv -----
// ----------------------------------------------------------------------------
// mf3_front: pixel intake, line stores and window
// Tracks the raster position, keeps the two previous rows in line stores and
// the two previous columns in a window, and pushes every interior window.
// ----------------------------------------------------------------------------
module mf3_front #(
   parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mf3_pkg::cfg_type                    cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   input  logic [mf3_pkg::LEVEL_BITS-1:0]      queue_level,
   output logic                                push,
   output logic [8:0][PIXEL_BITS-1:0]          push_pixels,
   output mf3_pkg::pos_type                    push_pos
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;
   localparam logic [CW-1:0] MAX_W = CW'(MAX_WIDTH);
   localparam logic [CW-1:0] MIN_W = CW'(mf3_pkg::MIN_SIDE);
   localparam logic [15:0]   MIN_H = 16'(mf3_pkg::MIN_SIDE);
   localparam int LW = mf3_pkg::LEVEL_BITS;

   // line stores
   logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];

   // position counters
   logic [AW-1:0] column_ff, column_in;
   logic [15:0]   row_ff, row_in;

   // second stage
   logic                  s2_valid_ff;
   logic                  s2_emit_ff;
   logic [PIXEL_BITS-1:0] s2_px_ff;
   logic [AW-1:0]         s2_addr_ff;
   mf3_pkg::pos_type      s2_pos_ff;
   logic [PIXEL_BITS-1:0] up_rd_ff, lo_rd_ff;

   // window: entries 0..2 column c-2, entries 3..5 column c-1 (top to bottom)
   logic [5:0][PIXEL_BITS-1:0] win_ff, win_in;

   logic                  accept;
   logic                  emit;
   logic [15:0]           px_wide;
   logic [PIXEL_BITS-1:0] px;
   logic [CW-1:0]         width_raw, width_eff, column_next;
   logic [15:0]           height_eff;
   logic [16:0]           row_next;
   logic [15:0]           column_less;
   logic [LW:0]           occupancy;
   mf3_pkg::pos_type      pos;

   // hold off intake while the queue could overflow
   assign occupancy  = {1'b0, queue_level} + (LW + 1)'(s2_valid_ff);
   assign req_tready = occupancy < (LW + 1)'(mf3_pkg::QUEUE_DEPTH);
   assign accept     = req_tvalid & req_tready;

   // take the low pixel bits of the transaction
   assign px_wide = {8'b0, req_tdata};
   assign px      = px_wide[PIXEL_BITS-1:0];

   // classify: interior once two columns and two rows have passed
   assign emit        = (column_ff >= AW'(2)) && (row_ff >= 16'd2);
   assign column_less = 16'(column_ff) - 16'd1;
   assign pos.column  = column_less[9:0];
   assign pos.row     = row_ff - 16'd1;

   // advance the raster position, clamping the frame size
   always_comb begin
      width_raw   = CW'(cfg.image_width);
      width_eff   = (width_raw < MIN_W) ? MIN_W : ((width_raw > MAX_W) ? MAX_W : width_raw);
      height_eff  = (cfg.image_height < MIN_H) ? MIN_H : cfg.image_height;
      column_next = CW'(column_ff) + CW'(1);
      row_next    = {1'b0, row_ff} + 17'd1;
      column_in   = column_ff;
      row_in      = row_ff;
      if (accept) begin
         if (column_next >= width_eff) begin
            column_in = '0;
            row_in    = (row_next >= {1'b0, height_eff}) ? 16'd0 : row_next[15:0];
         end else begin
            column_in = column_next[AW-1:0];
         end
      end
   end

   // shift the window by one column
   always_comb begin
      win_in = win_ff;
      if (s2_valid_ff) begin
         win_in[0] = win_ff[3];
         win_in[1] = win_ff[4];
         win_in[2] = win_ff[5];
         win_in[3] = up_rd_ff;
         win_in[4] = lo_rd_ff;
         win_in[5] = s2_px_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         row_ff      <= '0;
         s2_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         column_ff   <= column_in;
         row_ff      <= row_in;
         s2_valid_ff <= accept;
         win_ff      <= win_in;
      end
   end

   // read the line stores on intake, write them back in the cycle after
   always_ff @(posedge clock) begin
      if (accept) begin
         up_rd_ff   <= upper_mem[column_ff];
         lo_rd_ff   <= lower_mem[column_ff];
         s2_px_ff   <= px;
         s2_addr_ff <= column_ff;
         s2_emit_ff <= emit;
         s2_pos_ff  <= pos;
      end
      if (s2_valid_ff) begin
         upper_mem[s2_addr_ff] <= lo_rd_ff;
         lower_mem[s2_addr_ff] <= s2_px_ff;
      end
   end

   // hand the full window to the queue
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         push_pixels[k] = win_ff[k];
      end
      push_pixels[6] = up_rd_ff;
      push_pixels[7] = lo_rd_ff;
      push_pixels[8] = s2_px_ff;
   end

   assign push     = s2_valid_ff & s2_emit_ff;
   assign push_pos = s2_pos_ff;

endmodule

// ----- rtl/mf3_queue.sv -----
// ----------------------------------------------------------------------------
// mf3_queue: short window queue between front and back
// Register-based FIFO that lets the front keep taking pixels while the
// result side stalls.
// ----------------------------------------------------------------------------
module mf3_queue #(
   parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [8:0][PIXEL_BITS-1:0]     push_pixels,
   input  mf3_pkg::pos_type               push_pos,
   input  logic                           pop,
   output logic                           head_valid,
   output logic [8:0][PIXEL_BITS-1:0]     head_pixels,
   output mf3_pkg::pos_type               head_pos,
   output logic [mf3_pkg::LEVEL_BITS-1:0] level
);

   localparam int PW = mf3_pkg::QPTR_BITS;
   localparam int LW = mf3_pkg::LEVEL_BITS;
   localparam logic [PW-1:0] LAST = PW'(mf3_pkg::QUEUE_DEPTH - 1);

   logic [8:0][PIXEL_BITS-1:0] pix_ff [mf3_pkg::QUEUE_DEPTH];
   mf3_pkg::pos_type           pos_ff [mf3_pkg::QUEUE_DEPTH];
   logic [PW-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]              count_ff, count_in;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + LW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed window
   always_ff @(posedge clock) begin
      if (push) begin
         pix_ff[wr_ptr_ff] <= push_pixels;
         pos_ff[wr_ptr_ff] <= push_pos;
      end
   end

   assign head_valid  = (count_ff != '0);
   assign head_pixels = pix_ff[rd_ptr_ff];
   assign head_pos    = pos_ff[rd_ptr_ff];
   assign level       = count_ff;

endmodule

// ----- rtl/mf3_back.sv -----
// ----------------------------------------------------------------------------
// mf3_back: pipelined median network and result register
// Nineteen compare-exchange cells in three registered stages select the
// fifth smallest pixel; the whole pipeline holds while a result waits.
// ----------------------------------------------------------------------------
module mf3_back #(
   parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  logic [8:0][PIXEL_BITS-1:0] head_pixels,
   input  mf3_pkg::pos_type           head_pos,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 median_value,
   output mf3_pkg::pos_type           median_pos
);

   typedef logic [8:0][PIXEL_BITS-1:0] nine_type;

   nine_type         st1_ff, st2_ff;
   mf3_pkg::pos_type pos1_ff, pos2_ff, pos_out_ff;
   logic             v1_ff, v2_ff, out_valid_ff;
   logic [7:0]       median_ff;
   logic             advance;
   nine_type         st3;
   logic [15:0]      median_wide;

   // put the smaller value at a and the larger at b
   function automatic nine_type sort_pair(nine_type v, int a, int b);
      logic [PIXEL_BITS-1:0] lo_v;
      logic [PIXEL_BITS-1:0] hi_v;
      lo_v = (v[a] < v[b]) ? v[a] : v[b];
      hi_v = (v[a] < v[b]) ? v[b] : v[a];
      v[a] = lo_v;
      v[b] = hi_v;
      return v;
   endfunction

   // sort each column triple
   function automatic nine_type net_head(nine_type v);
      nine_type t;
      t = v;
      t = sort_pair(t, 1, 2);
      t = sort_pair(t, 4, 5);
      t = sort_pair(t, 7, 8);
      t = sort_pair(t, 0, 1);
      t = sort_pair(t, 3, 4);
      t = sort_pair(t, 6, 7);
      t = sort_pair(t, 1, 2);
      t = sort_pair(t, 4, 5);
      t = sort_pair(t, 7, 8);
      return t;
   endfunction

   // merge across columns
   function automatic nine_type net_mid(nine_type v);
      nine_type t;
      t = v;
      t = sort_pair(t, 0, 3);
      t = sort_pair(t, 5, 8);
      t = sort_pair(t, 4, 7);
      t = sort_pair(t, 3, 6);
      t = sort_pair(t, 1, 4);
      t = sort_pair(t, 2, 5);
      t = sort_pair(t, 4, 7);
      return t;
   endfunction

   // settle the middle element
   function automatic nine_type net_tail(nine_type v);
      nine_type t;
      t = v;
      t = sort_pair(t, 4, 2);
      t = sort_pair(t, 6, 4);
      t = sort_pair(t, 4, 2);
      return t;
   endfunction

   // stall everything only while a result is held and not taken
   assign advance = !out_valid_ff || rsp_tready;
   assign pop     = head_valid && advance;

   assign st3         = net_tail(st2_ff);
   assign median_wide = 16'(st3[mf3_pkg::MEDIAN_RANK]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= pop;
         v2_ff        <= v1_ff;
         out_valid_ff <= v2_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         st1_ff     <= net_head(head_pixels);
         pos1_ff    <= head_pos;
         st2_ff     <= net_mid(st1_ff);
         pos2_ff    <= pos1_ff;
         median_ff  <= median_wide[7:0];
         pos_out_ff <= pos2_ff;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign median_value = median_ff;
   assign median_pos   = pos_out_ff;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 3x3 median filter
// Streams raster pixels through the filter under random source gaps and sink
// stalls. A local model of the line stores and window predicts each median and
// its position, and the monitor compares every output transaction against it.
// Frame geometry is changed over the register port between phases, both at
// frame boundaries and mid-frame, covering the clamped widths and heights.
// ----------------------------------------------------------------------------
module tb;

   localparam int          MAX_W         = mf3_pkg::MAX_WIDTH_DEFAULT;
   localparam int          RANDOM_PIXELS = 1000;
   localparam int          FILL_WIDTH    = 16;
   localparam int          FILL_ROWS     = 4;
   localparam int          SETTLE_CYCLES = 10;
   localparam int          HOLD_AFTER    = 8;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          IDLE_LIMIT    = 2000;
   localparam logic [2:0]  WIDTH_ADDR    = {mf3_pkg::REG_IMAGE_WIDTH, 2'b00};
   localparam logic [2:0]  HEIGHT_ADDR   = {mf3_pkg::REG_IMAGE_HEIGHT, 2'b00};

   typedef struct packed {
      logic [7:0]       value;
      mf3_pkg::pos_type pos;
   } median_item_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;    // [7:0] pixel_in
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;             // [7:0] median_value, [17:8] out_column,
                                       // [33:18] out_row, [39:34] zero
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // pixels waiting for the driver, medians waiting for the monitor
   logic [7:0]      pixels_to_send [$];
   median_item_type medians_due [$];

   // filter model state
   logic [10:0]  geom_width  = mf3_pkg::IMAGE_WIDTH_RESET;
   logic [15:0]  geom_height = mf3_pkg::IMAGE_HEIGHT_RESET;
   logic [7:0]   row_far  [MAX_W];
   logic [7:0]   row_near [MAX_W];
   bit           far_set  [MAX_W] = '{default: 1'b0};
   bit           near_set [MAX_W] = '{default: 1'b0};
   logic [7:0]   band [6] = '{default: 8'd0};
   int unsigned  col_pos = 0;
   int unsigned  row_pos = 0;

   // bookkeeping
   int unsigned  pixels_sent     = 0;
   int unsigned  pixels_taken    = 0;
   int unsigned  medians_seen    = 0;
   int unsigned  geom_writes     = 0;
   int unsigned  mismatch_count  = 0;
   int unsigned  idle_cycles     = 0;
   int unsigned  gap_left        = 0;
   int unsigned  stall_left      = 0;
   int unsigned  hold_left       = 0;
   bit           hold_done       = 1'b0;
   bit           sender_steady   = 1'b0;
   bit           receiver_steady = 1'b0;

   median_filter_3x3 u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // count and report a failed comparison, detail for the first ten only
   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH %0d: %s", mismatch_count, what);
   endtask

   // frame width and height as the filter clamps them
   function automatic int unsigned eff_width();
      int unsigned w;
      w = (geom_width < mf3_pkg::MIN_SIDE) ? mf3_pkg::MIN_SIDE : geom_width;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      return (geom_height < mf3_pkg::MIN_SIDE) ? mf3_pkg::MIN_SIDE : geom_height;
   endfunction

   // fifth smallest of nine pixels, packed lowest first
   function automatic logic [7:0] middle_of_nine(input logic [71:0] nine);
      logic [7:0] v [9];
      logic [7:0] x;
      int         j;
      for (int i = 0; i < 9; i++) v[i] = nine[8*i +: 8];
      for (int i = 1; i < 9; i++) begin
         x = v[i];
         j = i - 1;
         while (j >= 0 && v[j] > x) begin
            v[j+1] = v[j];
            j--;
         end
         v[j+1] = x;
      end
      return v[mf3_pkg::MEDIAN_RANK];
   endfunction

   // longest run of up to want pixels whose medians only read written line
   // store entries; stop one pixel early so the next run starts on a safe spot
   function automatic int unsigned safe_burst(input int unsigned want);
      bit          far_look  [MAX_W];
      bit          near_look [MAX_W];
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned n;
      far_look  = far_set;
      near_look = near_set;
      w = eff_width();
      h = eff_height();
      c = col_pos;
      r = row_pos;
      for (n = 0; n < want; n++) begin
         if (c >= 2 && r >= 2 && !(far_look[c] && near_look[c])) break;
         far_look[c]  = near_look[c];
         near_look[c] = 1'b1;
         if (c + 1 >= w) begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            c++;
         end
      end
      return (n < want && n > 0) ? n - 1 : n;
   endfunction

   // advance the filter model by one pixel, queue the median it completes
   task automatic filter_pixel(input logic [7:0] px);
      int unsigned     w;
      int unsigned     h;
      logic [7:0]      above_far;
      logic [7:0]      above_near;
      median_item_type item;
      w = eff_width();
      h = eff_height();
      above_far  = row_far[col_pos];
      above_near = row_near[col_pos];
      if (col_pos >= 2 && row_pos >= 2) begin
         item.value = middle_of_nine({px, above_near, above_far, band[5], band[4],
                                      band[3], band[2], band[1], band[0]});
         item.pos.column = 10'(col_pos - 1);
         item.pos.row    = 16'(row_pos - 1);
         medians_due = {medians_due, item};
      end
      // shift the window left, move the column into the line stores
      band[0] = band[3];
      band[1] = band[4];
      band[2] = band[5];
      band[3] = above_far;
      band[4] = above_near;
      band[5] = px;
      row_far[col_pos]  = above_near;
      row_near[col_pos] = px;
      far_set[col_pos]  = near_set[col_pos];
      near_set[col_pos] = 1'b1;
      // wrap at row end and frame end, also when already past the limit
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
   endtask

   // compare one output transaction with the oldest predicted median
   task automatic check_median(input logic [39:0] data);
      median_item_type want;
      median_item_type got;
      got.value      = data[7:0];
      got.pos.column = data[17:8];
      got.pos.row    = data[33:18];
      medians_seen++;
      if (medians_due.size() == 0) begin
         note_mismatch($sformatf("unexpected median %0d at col %0d row %0d",
                                 got.value, got.pos.column, got.pos.row));
      end else begin
         want = medians_due.pop_front();
         if (got.value != want.value || got.pos.column != want.pos.column ||
             got.pos.row != want.pos.row)
            note_mismatch($sformatf("median exp %0d col %0d row %0d, got %0d col %0d row %0d",
                                    want.value, want.pos.column, want.pos.row,
                                    got.value, got.pos.column, got.pos.row));
      end
   endtask

   // driver: present queued pixels with random gaps, feed the model on transaction
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'd0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            filter_pixel(req_tdata);
            pixels_taken++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pixels_to_send.size() != 0) begin
            req_tdata  <= pixels_to_send.pop_front();
            req_tvalid <= 1'b1;
            gap_left   = sender_steady ? 0 : $urandom_range(0, 4);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: check each median, stall at random, hold off once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_median(rsp_tdata);
            stall_left = receiver_steady ? 0 : $urandom_range(0, 4);
         end
         if (!hold_done && medians_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: end the run when no transaction happens for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one register transaction: setup cycle, then access until pready
   task automatic csr_access(input bit is_write, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (is_write) begin
         geom_writes++;
         if (addr == WIDTH_ADDR) geom_width = wdata[10:0];
         else if (addr == HEIGHT_ADDR) geom_height = wdata[15:0];
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write the chosen geometry registers and read each one back
   task automatic set_geometry(input logic [31:0] wval, input logic [31:0] hval,
                               input bit set_w, input bit set_h);
      logic [31:0] readback;
      if (set_w) begin
         csr_access(1'b1, WIDTH_ADDR, wval, readback);
         csr_access(1'b0, WIDTH_ADDR, 32'd0, readback);
         if (readback != {21'd0, wval[10:0]})
            note_mismatch($sformatf("width readback exp %0d got %0d", wval[10:0], readback));
      end
      if (set_h) begin
         csr_access(1'b1, HEIGHT_ADDR, hval, readback);
         csr_access(1'b0, HEIGHT_ADDR, 32'd0, readback);
         if (readback != {16'd0, hval[15:0]})
            note_mismatch($sformatf("height readback exp %0d got %0d", hval[15:0], readback));
      end
   endtask

   // wait until every pixel is taken and every median is out, then let it settle
   task automatic wait_idle();
      while (pixels_taken != pixels_sent || medians_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_pixel(input logic [7:0] px);
      pixels_to_send = {pixels_to_send, px};
      pixels_sent++;
   endtask

   initial begin
      logic [31:0] readback;
      logic [31:0] wval;
      logic [31:0] hval;
      logic [7:0]  base;
      logic [7:0]  px;
      int unsigned random_pixels;
      int unsigned burst;
      int unsigned flavor;
      int unsigned which;

      random_pixels = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the geometry registers
      csr_access(1'b0, WIDTH_ADDR, 32'd0, readback);
      if (readback != {21'd0, mf3_pkg::IMAGE_WIDTH_RESET})
         note_mismatch($sformatf("width after reset %0d", readback));
      csr_access(1'b0, HEIGHT_ADDR, 32'd0, readback);
      if (readback != {16'd0, mf3_pkg::IMAGE_HEIGHT_RESET})
         note_mismatch($sformatf("height after reset %0d", readback));

      // smallest frame, alternating full scale pixels
      set_geometry(32'd3, 32'd3, 1'b1, 1'b1);
      @(negedge clock);
      for (int i = 0; i < 9; i++) queue_pixel((i % 2 == 0) ? 8'hFF : 8'h00);
      wait_idle();

      // width and height below the minimum clamp to three, walk a one bit
      set_geometry(32'd1, 32'd2, 1'b1, 1'b1);
      @(negedge clock);
      for (int i = 0; i < 8; i++) queue_pixel(8'd1 << i);
      queue_pixel(8'hFF);
      wait_idle();

      // whole frame that fills the low line store columns, long sink hold here
      set_geometry(32'(FILL_WIDTH), 32'(FILL_ROWS), 1'b1, 1'b1);
      @(negedge clock);
      for (int i = 0; i < FILL_WIDTH * FILL_ROWS; i++) queue_pixel(8'($urandom));
      wait_idle();

      // random phases, geometry changed at arbitrary frame positions
      while (random_pixels < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0:       wval = $urandom_range(0, 2);
            1:       wval = 32'd1024;
            2:       wval = ($urandom & 32'hFFFF_F800) | $urandom_range(1025, 2047);
            default: wval = $urandom_range(3, 12);
         endcase
         case ($urandom_range(0, 9))
            0:       hval = $urandom_range(0, 2);
            1:       hval = 32'd65535;
            2:       hval = $urandom;
            default: hval = $urandom_range(3, 8);
         endcase
         which = $urandom_range(0, 3);
         set_geometry(wval, hval, which != 1, which != 0);
         @(negedge clock);
         sender_steady   = ($urandom_range(0, 3) == 0);
         receiver_steady = ($urandom_range(0, 3) == 0);
         burst  = safe_burst($urandom_range(20, 90));
         flavor = $urandom_range(0, 3);
         base   = $urandom;
         for (int i = 0; i < burst; i++) begin
            case (flavor)
               1:       px = base ^ 8'($urandom_range(0, 3));
               2:       px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               default: px = $urandom;
            endcase
            queue_pixel(px);
         end
         random_pixels += burst;
         wait_idle();
      end

      $display("Sent %0d pixels and checked %0d medians over %0d register writes,",
               pixels_sent, medians_seen, geom_writes);
      $display("with clamped widths and heights and geometry changes inside frames.");
      if (mismatch_count == 0 && medians_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d medians missing", mismatch_count, medians_due.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
